// File: rtl/cpps_pkg.sv
// Package with the types and constants of the controller port poll and status core.
package cpps_pkg;

    localparam int CHANNELS  = 4;
    localparam int LINE_BITS = 10;

    localparam int CMD_BITS   = 3;
    localparam int IVAL_BITS  = 10;
    localparam int BUDGET_BITS = 8;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 10;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LINE_TICK    = 3'd0,
        CMD_READ_PAD     = 3'd1,
        CMD_ACK_DONE     = 3'd2,
        CMD_TRANSFER     = 3'd3,
        CMD_CLEAR_ERRORS = 3'd4
    } cmd_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_POLL_INTERVAL    = 3'd0,
        REG_POLLS_PER_FRAME  = 3'd1,
        REG_POLL_ENABLE      = 3'd2,
        REG_READY_IRQ_ENABLE = 3'd3,
        REG_DONE_IRQ_ENABLE  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] command;
        logic [9:0]          line;
        logic [3:0]          device_answers;
        logic [1:0]          channel;
        logic                device_present;
        logic [3:0]          clear_mask;
    } item_t;

    typedef struct packed {
        logic [3:0] polled_channels;
        logic       irq_line;
        logic       com_error;
        logic [3:0] no_response;
        logic       done_irq;
        logic       ready_irq;
        logic [3:0] ready_flags;
    } result_t;

endpackage

// File: rtl/controller_port_poll_and_status.sv
// Path: an accepted beat is held in the input register and processed, and its result is
// registered in the result register, which drives the output; these are separate stages.
// Throughput: one beat per cycle unless the output stalls; the whole status update is
// one pass of compare and flag logic.
// Reset: asynchronous and active low; both stages empty, all status and schedule state
// cleared with a first poll due, poll_enable set to all channels and other registers zero.
module controller_port_poll_and_status (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cpps_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [cpps_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: line[9:0], device_answers[13:10], channel[15:14],
    // device_present[16], clear_mask[20:17], zero fill[23:21].
    input  logic [23:0]                        s_tdata,
    // Fields from bit 0: command[2:0].
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0: ready_flags[3:0], ready_irq[4], done_irq[5], no_response[9:6],
    // com_error[10], irq_line[11], polled_channels[15:12].
    output logic [15:0]                        m_tdata
);
    import cpps_pkg::*;

    logic [IVAL_BITS-1:0]   poll_interval_reg;
    logic [BUDGET_BITS-1:0] polls_per_frame_reg;
    logic [CHANNELS-1:0]    poll_enable_reg;
    logic                   ready_irq_enable_reg;
    logic                   done_irq_enable_reg;

    logic [LINE_BITS-1:0]   previous_line_reg, previous_line_next;
    logic [LINE_BITS-1:0]   poll_base_line_reg, poll_base_line_next;
    logic [BUDGET_BITS-1:0] polls_done_reg, polls_done_next;
    logic                   first_poll_due_reg, first_poll_due_next;
    logic [CHANNELS-1:0]    ready_bits_reg, ready_bits_next;
    logic                   ready_latch_reg, ready_latch_next;
    logic                   done_latch_reg, done_latch_next;
    logic [CHANNELS-1:0]    error_bits_reg, error_bits_next;
    logic                   error_summary_reg, error_summary_next;
    logic                   irq_level_reg, irq_level_next;

    item_t                  item_reg;
    logic                   item_valid_reg;
    result_t                result_reg, result_next;
    logic                   result_valid_reg;

    logic                   out_free;
    logic                   advance;
    logic [LINE_BITS-1:0]   line_v;
    logic [LINE_BITS-1:0]   line_gap;
    logic [CHANNELS-1:0]    chan_bit;
    logic [CHANNELS-1:0]    polled;
    logic [CHANNELS-1:0]    answered;
    logic                   poll_now;

    assign out_free = !result_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;
    assign m_tvalid = result_valid_reg;
    assign m_tdata  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg    <= '0;
            polls_per_frame_reg  <= '0;
            poll_enable_reg      <= '1;
            ready_irq_enable_reg <= 1'b0;
            done_irq_enable_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_POLL_INTERVAL:    poll_interval_reg    <= cfg_wdata[IVAL_BITS-1:0];
                REG_POLLS_PER_FRAME:  polls_per_frame_reg  <= cfg_wdata[BUDGET_BITS-1:0];
                REG_POLL_ENABLE:      poll_enable_reg      <= cfg_wdata[CHANNELS-1:0];
                REG_READY_IRQ_ENABLE: ready_irq_enable_reg <= cfg_wdata[0];
                REG_DONE_IRQ_ENABLE:  done_irq_enable_reg  <= cfg_wdata[0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                item_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.command        <= s_tuser;
            item_reg.line           <= s_tdata[9:0];
            item_reg.device_answers <= s_tdata[13:10];
            item_reg.channel        <= s_tdata[15:14];
            item_reg.device_present <= s_tdata[16];
            item_reg.clear_mask     <= s_tdata[20:17];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_line_reg  <= '0;
            poll_base_line_reg <= '0;
            polls_done_reg     <= '0;
            first_poll_due_reg <= 1'b1;
            ready_bits_reg     <= '0;
            ready_latch_reg    <= 1'b0;
            done_latch_reg     <= 1'b0;
            error_bits_reg     <= '0;
            error_summary_reg  <= 1'b0;
            irq_level_reg      <= 1'b0;
        end
        else if (advance)
        begin
            previous_line_reg  <= previous_line_next;
            poll_base_line_reg <= poll_base_line_next;
            polls_done_reg     <= polls_done_next;
            first_poll_due_reg <= first_poll_due_next;
            ready_bits_reg     <= ready_bits_next;
            ready_latch_reg    <= ready_latch_next;
            done_latch_reg     <= done_latch_next;
            error_bits_reg     <= error_bits_next;
            error_summary_reg  <= error_summary_next;
            irq_level_reg      <= irq_level_next;
        end
    end

    always_comb
    begin
        line_v   = LINE_BITS'(item_reg.line);
        line_gap = line_v - poll_base_line_reg;
        chan_bit = CHANNELS'(1) << item_reg.channel;
        polled   = '0;
        answered = poll_enable_reg & CHANNELS'(item_reg.device_answers);
        poll_now = 1'b0;

        previous_line_next  = previous_line_reg;
        poll_base_line_next = poll_base_line_reg;
        polls_done_next     = polls_done_reg;
        first_poll_due_next = first_poll_due_reg;
        ready_bits_next     = ready_bits_reg;
        ready_latch_next    = ready_latch_reg;
        done_latch_next     = done_latch_reg;
        error_bits_next     = error_bits_reg;
        error_summary_next  = error_summary_reg;
        irq_level_next      = irq_level_reg;

        unique case (item_reg.command)
            CMD_LINE_TICK:
            begin
                if (line_v < previous_line_reg)
                begin
                    polls_done_next     = '0;
                    first_poll_due_next = 1'b1;
                end
                previous_line_next = line_v;
                poll_now = (poll_interval_reg != '0) && (polls_per_frame_reg != '0)
                    && (polls_done_next < polls_per_frame_reg)
                    && (first_poll_due_next || (line_v < poll_base_line_reg)
                        || (IVAL_BITS'(line_gap) >= poll_interval_reg));
                if (poll_now)
                begin
                    first_poll_due_next = 1'b0;
                    poll_base_line_next = line_v;
                    polls_done_next     = polls_done_next + BUDGET_BITS'(1);
                    polled              = poll_enable_reg;
                    if (answered != '0)
                    begin
                        ready_bits_next  = ready_bits_reg | answered;
                        ready_latch_next = 1'b1;
                    end
                    if (ready_latch_next && ready_irq_enable_reg)
                    begin
                        irq_level_next = 1'b1;
                    end
                end
            end
            CMD_READ_PAD:
            begin
                ready_bits_next = ready_bits_reg & ~chan_bit;
                if (ready_bits_next == '0)
                begin
                    ready_latch_next = 1'b0;
                    if (!done_latch_reg)
                    begin
                        irq_level_next = 1'b0;
                    end
                end
            end
            CMD_ACK_DONE:
            begin
                done_latch_next = 1'b0;
                if (!ready_latch_reg)
                begin
                    irq_level_next = 1'b0;
                end
            end
            CMD_TRANSFER:
            begin
                error_summary_next = !item_reg.device_present;
                if (!item_reg.device_present)
                begin
                    error_bits_next = error_bits_reg | chan_bit;
                end
                done_latch_next = 1'b1;
                if (done_irq_enable_reg)
                begin
                    irq_level_next = 1'b1;
                end
            end
            CMD_CLEAR_ERRORS:
            begin
                error_bits_next = error_bits_reg & ~CHANNELS'(item_reg.clear_mask);
            end
            default:
            begin
            end
        endcase

        result_next.ready_flags     = 4'(ready_bits_next);
        result_next.ready_irq       = ready_latch_next;
        result_next.done_irq        = done_latch_next;
        result_next.no_response     = 4'(error_bits_next);
        result_next.com_error       = error_summary_next;
        result_next.irq_line        = irq_level_next;
        result_next.polled_channels = 4'(polled);
    end

    // The interrupt line is only ever high while one of the latches holds it.
    assert property (@(posedge clk) disable iff (!rst_n)
        irq_level_reg |-> (ready_latch_reg || done_latch_reg))
        else $error("interrupt line high with both latches clear");

    // Pending poll data always keeps the ready latch set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ready_bits_reg != '0) |-> ready_latch_reg)
        else $error("ready flags set without the ready latch");

    // A held beat in the input stage is neither lost nor changed while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_valid_reg && !m_tready)
            |=> (item_valid_reg && $stable(item_reg)))
        else $error("input stage changed while the result stage was blocked");

    // State moves only when a beat is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(ready_bits_reg) && $stable(polls_done_reg)
            && $stable(irq_level_reg)))
        else $error("status changed without a processed beat");

endmodule

// File: tb/poll_status_monitor.sv
// Checker that predicts and compares the status beats of the controller port poll and status core.
module poll_status_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [cpps_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [cpps_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [23:0]                        s_tdata,
    input  logic [2:0]                         s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [15:0]                        m_tdata,
    output int unsigned                        fail_count,
    output int unsigned                        pending
);
    import cpps_pkg::*;

    logic [9:0] interval;
    logic [7:0] budget;
    logic [3:0] poll_mask;
    logic       ready_ie;
    logic       done_ie;

    logic [9:0] prev_line;
    logic [9:0] base_line;
    logic [7:0] polls_done;
    logic       first_due;
    logic [3:0] ready_bits;
    logic       ready_latch;
    logic       done_latch;
    logic [3:0] err_bits;
    logic       err_summary;
    logic       irq;

    result_t     status_q [$];
    int unsigned errors;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    function automatic void drop_irq_if_clear();
        if (!ready_latch && !done_latch)
            irq = 1'b0;
    endfunction

    function automatic logic [3:0] advance_line(logic [9:0] line, logic [3:0] answers);
        logic [3:0] hit;
        if (line < prev_line)
        begin
            polls_done = '0;
            first_due  = 1'b1;
        end
        prev_line = line;
        if (budget == 0 || interval == 0 || polls_done >= budget)
            return 4'd0;
        if (!first_due && line >= base_line && (line - base_line) < interval)
            return 4'd0;
        first_due  = 1'b0;
        base_line  = line;
        polls_done = polls_done + 8'd1;
        hit = poll_mask & answers;
        if (hit != 0)
        begin
            ready_bits  = ready_bits | hit;
            ready_latch = 1'b1;
        end
        if (ready_latch && ready_ie)
            irq = 1'b1;
        return poll_mask;
    endfunction

    function automatic result_t predict_status(logic [2:0] cmd, logic [23:0] data);
        logic [9:0] line;
        logic [3:0] answers;
        logic [3:0] chan_bit;
        logic       present;
        logic [3:0] clear;
        logic [3:0] polled;
        result_t    r;
        line     = data[9:0];
        answers  = data[13:10];
        chan_bit = 4'd1 << data[15:14];
        present  = data[16];
        clear    = data[20:17];
        polled   = 4'd0;
        unique case (cmd)
            CMD_LINE_TICK:
                polled = advance_line(line, answers);
            CMD_READ_PAD:
            begin
                ready_bits = ready_bits & ~chan_bit;
                if (ready_bits == 0)
                begin
                    ready_latch = 1'b0;
                    drop_irq_if_clear();
                end
            end
            CMD_ACK_DONE:
            begin
                done_latch = 1'b0;
                drop_irq_if_clear();
            end
            CMD_TRANSFER:
            begin
                err_summary = !present;
                if (!present)
                    err_bits = err_bits | chan_bit;
                done_latch = 1'b1;
                if (done_ie)
                    irq = 1'b1;
            end
            CMD_CLEAR_ERRORS:
                err_bits = err_bits & ~clear;
            default:
                ;
        endcase
        r.ready_flags     = ready_bits;
        r.ready_irq       = ready_latch;
        r.done_irq        = done_latch;
        r.no_response     = err_bits;
        r.com_error       = err_summary;
        r.irq_line        = irq;
        r.polled_channels = polled;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            interval    = '0;
            budget      = '0;
            poll_mask   = 4'hF;
            ready_ie    = 1'b0;
            done_ie     = 1'b0;
            prev_line   = '0;
            base_line   = '0;
            polls_done  = '0;
            first_due   = 1'b1;
            ready_bits  = '0;
            ready_latch = 1'b0;
            done_latch  = 1'b0;
            err_bits    = '0;
            err_summary = 1'b0;
            irq         = 1'b0;
            status_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    REG_POLL_INTERVAL:    interval  = cfg_wdata[9:0];
                    REG_POLLS_PER_FRAME:  budget    = cfg_wdata[7:0];
                    REG_POLL_ENABLE:      poll_mask = cfg_wdata[3:0];
                    REG_READY_IRQ_ENABLE: ready_ie  = cfg_wdata[0];
                    REG_DONE_IRQ_ENABLE:  done_ie   = cfg_wdata[0];
                    default:              ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                if (status_q.size() == 0)
                begin
                    $error("status beat 0x%04h arrived with no command outstanding", m_tdata);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("ready_flags", 32'(want.ready_flags), 32'(got.ready_flags));
                    check_field("ready_irq", 32'(want.ready_irq), 32'(got.ready_irq));
                    check_field("done_irq", 32'(want.done_irq), 32'(got.done_irq));
                    check_field("no_response", 32'(want.no_response), 32'(got.no_response));
                    check_field("com_error", 32'(want.com_error), 32'(got.com_error));
                    check_field("irq_line", 32'(want.irq_line), 32'(got.irq_line));
                    check_field("polled_channels", 32'(want.polled_channels),
                                32'(got.polled_channels));
                end
            end
            if (s_tvalid && s_tready)
                status_q.push_back(predict_status(s_tuser, s_tdata));
            pending <= status_q.size();
        end
        fail_count <= errors;
    end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, command stimulus, register setup and the verdict.
module testbench;
    import cpps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 100;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;
    logic [2:0]               s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [15:0]              m_tdata;
    int unsigned              fail_count;
    int unsigned              pending;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    logic [9:0]  cur_line;

    controller_port_poll_and_status dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    poll_status_monitor status_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(1, 100) > stall_pct);
        end
    end

    task automatic send_beat(input logic [2:0] cmd, input logic [9:0] line,
                             input logic [3:0] answers, input logic [1:0] channel,
                             input logic present, input logic [3:0] clear);
        while ($urandom_range(1, 100) <= send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, clear, present, channel, answers, line};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [9:0] ival, input logic [7:0] budget,
                                input logic [3:0] enable, input logic rdy_ie,
                                input logic done_ie);
        reg_index_t               order [5] = '{REG_POLL_INTERVAL, REG_POLLS_PER_FRAME,
                                                REG_POLL_ENABLE, REG_READY_IRQ_ENABLE,
                                                REG_DONE_IRQ_ENABLE};
        logic [CFG_DATA_BITS-1:0] vals [5];
        vals[0] = ival;
        vals[1] = {2'b00, budget};
        vals[2] = {6'd0, enable};
        vals[3] = {9'd0, rdy_ie};
        vals[4] = {9'd0, done_ie};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [2:0]  cmd;
        logic [9:0]  line;
        logic [10:0] nxt;
        pick = $urandom_range(0, 99);
        line = 10'($urandom_range(0, 1023));
        if (pick < 40)
        begin
            cmd = CMD_LINE_TICK;
            if ($urandom_range(0, 29) == 0)
            begin
                cur_line = 10'($urandom_range(0, 20));
            end
            else if ($urandom_range(0, 19) != 0)
            begin
                nxt = 11'(cur_line) + 11'($urandom_range(0, 12));
                cur_line = (nxt > 1023) ? 10'($urandom_range(0, 5)) : nxt[9:0];
            end
            else
            begin
                cur_line = line;
            end
            line = cur_line;
        end
        else if (pick < 58)
        begin
            cmd = CMD_READ_PAD;
        end
        else if (pick < 68)
        begin
            cmd = CMD_ACK_DONE;
        end
        else if (pick < 83)
        begin
            cmd = CMD_TRANSFER;
        end
        else if (pick < 95)
        begin
            cmd = CMD_CLEAR_ERRORS;
        end
        else
        begin
            cmd = 3'($urandom_range(5, 7));
        end
        send_beat(cmd, line, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        int unsigned idle_table  [4] = '{0, 71, 0, 21};
        int unsigned stall_table [4] = '{0, 0, 71, 21};
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cur_line      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: polling is off and no interrupt is enabled.
        send_beat(CMD_LINE_TICK, 10'd0, 4'hF, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_TRANSFER, 10'd0, 4'h0, 2'd1, 1'b0, 4'h0);
        send_beat(CMD_CLEAR_ERRORS, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_CLEAR_ERRORS, 10'h3FF, 4'hF, 2'd3, 1'b1, 4'hF);
        drain();

        program_regs(10'd1, 8'd255, 4'hF, 1'b1, 1'b1);
        send_beat(CMD_LINE_TICK, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_LINE_TICK, 10'd1, 4'hF, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_LINE_TICK, 10'd1, 4'hF, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_LINE_TICK, 10'h3FF, 4'h5, 2'd3, 1'b1, 4'hF);
        send_beat(CMD_READ_PAD, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_READ_PAD, 10'd0, 4'h0, 2'd1, 1'b0, 4'h0);
        send_beat(CMD_READ_PAD, 10'd0, 4'h0, 2'd2, 1'b0, 4'h0);
        send_beat(CMD_READ_PAD, 10'd0, 4'h0, 2'd3, 1'b0, 4'h0);
        send_beat(CMD_TRANSFER, 10'd0, 4'h0, 2'd3, 1'b0, 4'h0);
        send_beat(CMD_ACK_DONE, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_TRANSFER, 10'd0, 4'h0, 2'd2, 1'b1, 4'h0);
        send_beat(CMD_CLEAR_ERRORS, 10'd0, 4'h0, 2'd0, 1'b0, 4'hF);
        send_beat(3'd5, 10'h3FF, 4'hF, 2'd3, 1'b1, 4'hF);
        send_beat(3'd6, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        send_beat(3'd7, 10'h155, 4'hA, 2'd1, 1'b0, 4'h5);
        send_beat(CMD_LINE_TICK, 10'd3, 4'h8, 2'd0, 1'b0, 4'h0);
        send_beat(CMD_ACK_DONE, 10'd0, 4'h0, 2'd0, 1'b0, 4'h0);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       program_regs(10'h3FF, 8'd255, 4'hF, 1'b1, 1'b1);
                1:       program_regs(10'd0, 8'd255, 4'hF, 1'b1, 1'b1);
                2:       program_regs(10'd1, 8'd1, 4'h0, 1'b0, 1'b0);
                3:       program_regs(10'd5, 8'd0, 4'hA, 1'b1, 1'b0);
                default: program_regs(10'($urandom_range(1, 64)), 8'($urandom_range(1, 8)),
                                      4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)));
            endcase
            send_idle_pct = idle_table[seg % 4];
            stall_pct     = stall_table[seg % 4];
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send_random();
            drain();
            stall_pct = 0;
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[controller_port_poll_and_status] OK");
        else
            $display("[controller_port_poll_and_status] ERROR");
        $finish;
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("[controller_port_poll_and_status] ERROR");
        $finish;
    end

endmodule
